/* rtl/core/ncc_pkg.sv */
package ncc_pkg;

    // Sizing of the classifier and the confusion matrix.
    localparam int NUM_CENTERS = 6;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;

    // Configuration port.
    localparam int NUM_CFG     = 6;
    localparam int CFG_DATA_W  = 36;
    localparam int CFG_INDEX_W = 3;

    // Fixed field widths of the stream words.
    localparam int OP_W       = 2;
    localparam int TC_W       = 3;
    localparam int WINNER_W   = 3;
    localparam int MIN_DIST_W = 26;
    localparam int CELL_W     = 16;

    // Derived internal widths.
    localparam int IDX_W  = $clog2(NUM_CENTERS);
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int DIST_W = SQ_W + 2;
    localparam int CTR_W  = 3 * SAMPLE_BITS;

    // Minimum search tree and front pipeline depth.
    localparam int TREE_LEVELS = $clog2(NUM_CENTERS);
    localparam int LEAVES      = 1 << TREE_LEVELS;
    localparam int HALF_LEAVES = LEAVES / 2;
    localparam int FRONT_LAT   = 3 + TREE_LEVELS;

    // Queue between the front and the back.
    localparam int QUEUE_AW    = $clog2(FRONT_LAT + 3);
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Confusion matrix storage.
    localparam int NUM_CELLS   = NUM_CENTERS * NUM_CENTERS;
    localparam int CELL_ADDR_W = $clog2(NUM_CELLS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Result buffer in the back.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + TC_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = OP_W;
    localparam int OUT_TDATA_W = ((WINNER_W + MIN_DIST_W + CELL_W + 7) / 8) * 8;

    // Operation codes; the unused code behaves as a plain classify.
    typedef enum logic [OP_W-1:0] {
        OP_CLASSIFY = 2'd0,
        OP_COUNT    = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    typedef logic [NUM_CENTERS-1:0][CTR_W-1:0] centers_t;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [SAMPLE_BITS-1:0] sx;
        logic [SAMPLE_BITS-1:0] sy;
        logic [SAMPLE_BITS-1:0] sz;
        logic [TC_W-1:0]        tc;
    } in_item_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TC_W-1:0]   tc;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } front_item_t;

    typedef struct packed {
        logic                not_empty;
        logic [QUEUE_AW:0]   count;
    } q_stat_t;

endpackage

/* rtl/core/ncc_front.sv */
module ncc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  ncc_pkg::in_item_t     in_item,
    input  ncc_pkg::centers_t     centers,
    output logic                  out_valid,
    output ncc_pkg::front_item_t  out_item
);

    localparam int SB = ncc_pkg::SAMPLE_BITS;
    localparam int NC = ncc_pkg::NUM_CENTERS;
    localparam int FL = ncc_pkg::FRONT_LAT;
    localparam int TL = ncc_pkg::TREE_LEVELS;
    localparam int LV = ncc_pkg::LEAVES;
    localparam int HL = ncc_pkg::HALF_LEAVES;

    logic [FL-1:0]                        vld_reg;
    logic [FL-1:0][ncc_pkg::OP_W-1:0]     op_reg;
    logic [FL-1:0][ncc_pkg::TC_W-1:0]     tc_reg;

    logic [2:0][SB-1:0]                   samp;
    logic [NC-1:0][2:0][SB-1:0]           absdiff_next;
    logic [NC-1:0][2:0][SB-1:0]           absdiff_reg;
    logic [NC-1:0][2:0][ncc_pkg::SQ_W-1:0] sq_reg;
    logic [LV-1:0][ncc_pkg::DIST_W-1:0]   leaf_d_next;
    logic [LV-1:0][ncc_pkg::DIST_W-1:0]   leaf_d_reg;

    logic [TL:0][LV-1:0][ncc_pkg::DIST_W-1:0] lvl_d;
    logic [TL:0][LV-1:0][ncc_pkg::IDX_W-1:0]  lvl_i;
    logic [TL:0][LV-1:0]                      lvl_ok;

    logic [TL-1:0][HL-1:0][ncc_pkg::DIST_W-1:0] tree_d_next;
    logic [TL-1:0][HL-1:0][ncc_pkg::IDX_W-1:0]  tree_i_next;
    logic [TL-1:0][HL-1:0]                      tree_ok_next;
    logic [TL-1:0][HL-1:0][ncc_pkg::DIST_W-1:0] tree_d_reg;
    logic [TL-1:0][HL-1:0][ncc_pkg::IDX_W-1:0]  tree_i_reg;
    logic [TL-1:0][HL-1:0]                      tree_ok_reg;

    // Valid bits and side fields travel beside the distance pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[FL-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= {op_reg[FL-2:0], in_item.op};
        tc_reg <= {tc_reg[FL-2:0], in_item.tc};
    end

    // First stage: absolute difference per centre and axis.
    assign samp = {in_item.sz, in_item.sy, in_item.sx};

    always_comb begin
        logic [SB-1:0] ctr_axis;
        ctr_axis = '0;
        for (int c = 0; c < NC; c++) begin
            for (int a = 0; a < 3; a++) begin
                ctr_axis = centers[c][a*SB +: SB];
                absdiff_next[c][a] = (ctr_axis >= samp[a]) ? (ctr_axis - samp[a])
                                                             : (samp[a] - ctr_axis);
            end
        end
    end

    always_ff @(posedge aclk) begin
        absdiff_reg <= absdiff_next;
    end

    // Second stage: one square per axis.
    always_ff @(posedge aclk) begin
        for (int c = 0; c < NC; c++) begin
            for (int a = 0; a < 3; a++) begin
                sq_reg[c][a] <= ncc_pkg::SQ_W'(absdiff_reg[c][a])
                              * ncc_pkg::SQ_W'(absdiff_reg[c][a]);
            end
        end
    end

    // Third stage: sum of the three squares; unused leaves are zero.
    always_comb begin
        for (int n = 0; n < LV; n++) begin
            if (n < NC) begin
                leaf_d_next[n] = ncc_pkg::DIST_W'(sq_reg[n][0])
                               + ncc_pkg::DIST_W'(sq_reg[n][1])
                               + ncc_pkg::DIST_W'(sq_reg[n][2]);
            end else begin
                leaf_d_next[n] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        leaf_d_reg <= leaf_d_next;
    end

    // Tree inputs: level zero are the leaves, level l+1 the registers of level l.
    always_comb begin
        for (int n = 0; n < LV; n++) begin
            lvl_d[0][n]  = leaf_d_reg[n];
            lvl_i[0][n]  = ncc_pkg::IDX_W'(n);
            lvl_ok[0][n] = (n < NC);
        end
        for (int l = 0; l < TL; l++) begin
            for (int n = 0; n < LV; n++) begin
                if (n < HL) begin
                    lvl_d[l+1][n]  = tree_d_reg[l][n];
                    lvl_i[l+1][n]  = tree_i_reg[l][n];
                    lvl_ok[l+1][n] = tree_ok_reg[l][n];
                end else begin
                    lvl_d[l+1][n]  = '0;
                    lvl_i[l+1][n]  = '0;
                    lvl_ok[l+1][n] = 1'b0;
                end
            end
        end
    end

    // Each tree level keeps the left entry unless the right one is strictly
    // nearer, so the lowest index wins a tie.
    always_comb begin
        logic take_right;
        take_right = 1'b0;
        for (int l = 0; l < TL; l++) begin
            for (int n = 0; n < HL; n++) begin
                take_right = lvl_ok[l][2*n+1] && (lvl_d[l][2*n+1] < lvl_d[l][2*n]);
                tree_d_next[l][n]  = take_right ? lvl_d[l][2*n+1] : lvl_d[l][2*n];
                tree_i_next[l][n]  = take_right ? lvl_i[l][2*n+1] : lvl_i[l][2*n];
                tree_ok_next[l][n] = lvl_ok[l][2*n] | lvl_ok[l][2*n+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        tree_d_reg  <= tree_d_next;
        tree_i_reg  <= tree_i_next;
        tree_ok_reg <= tree_ok_next;
    end

    // Classified word toward the queue.
    assign out_valid        = vld_reg[FL-1];
    assign out_item.op      = op_reg[FL-1];
    assign out_item.tc      = tc_reg[FL-1];
    assign out_item.idx     = tree_i_reg[TL-1][0];
    assign out_item.dist_sq = tree_d_reg[TL-1][0];

endmodule

/* rtl/core/ncc_queue.sv */
module ncc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ncc_pkg::front_item_t  push_item,
    input  logic                  pop,
    output ncc_pkg::front_item_t  head_item,
    output ncc_pkg::q_stat_t      stat
);

    localparam int AW = ncc_pkg::QUEUE_AW;

    ncc_pkg::front_item_t [ncc_pkg::QUEUE_DEPTH-1:0] slot_reg;
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage of the queued words.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = slot_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.count     = count_reg;

endmodule

/* rtl/core/ncc_back.sv */
module ncc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ncc_pkg::q_stat_t                    q_stat,
    input  ncc_pkg::front_item_t                q_item,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ncc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int AW = ncc_pkg::OUT_AW;
    localparam int CB = ncc_pkg::COUNT_BITS;
    localparam int CA = ncc_pkg::CELL_ADDR_W;

    // Words in flight inside the back, result buffer included.
    logic [AW:0] back_cnt_reg;
    logic [AW:0] back_cnt_next;
    logic        take;

    logic                  b1_valid_reg;
    ncc_pkg::front_item_t  b1_item_reg;
    logic [CA-1:0]         b1_addr;
    logic                  b1_count_en;

    logic                  b2_valid_reg;
    ncc_pkg::front_item_t  b2_item_reg;
    logic [CA-1:0]         b2_addr_reg;
    logic                  b2_count_en_reg;

    logic [CB-1:0] cell_mem [ncc_pkg::NUM_CELLS];
    logic [CB-1:0] rd_data_reg;
    logic [ncc_pkg::NUM_CELLS-1:0] cell_vld_reg;

    logic          last_wr_reg;
    logic [CA-1:0] last_addr_reg;
    logic [CB-1:0] last_data_reg;

    logic          fwd;
    logic [CB-1:0] cnt_old;
    logic [CB-1:0] cnt_new;
    logic          wr_en;
    logic          clr;

    logic [ncc_pkg::IDX_W+ncc_pkg::WINNER_W-1:0]    winner_ext;
    logic [ncc_pkg::DIST_W+ncc_pkg::MIN_DIST_W-1:0] dist_ext;
    logic [CB+ncc_pkg::CELL_W-1:0]                  cell_ext;
    logic [ncc_pkg::WINNER_W-1:0]                   res_winner;
    logic [ncc_pkg::MIN_DIST_W-1:0]                 res_dist;
    logic [ncc_pkg::CELL_W-1:0]                     res_cell;

    logic [ncc_pkg::OUT_DEPTH-1:0][ncc_pkg::OUT_TDATA_W-1:0] ob_reg;
    logic [AW-1:0] ob_wr_ptr_reg;
    logic [AW-1:0] ob_rd_ptr_reg;
    logic [AW:0]   ob_cnt_reg;

    // Pop only while the result buffer has room for everything in flight.
    assign q_pop = q_stat.not_empty && (back_cnt_reg < (AW+1)'(ncc_pkg::OUT_DEPTH));
    assign take  = m_axis_tvalid && m_axis_tready;
    assign back_cnt_next = back_cnt_reg + (AW+1)'(q_pop) - (AW+1)'(take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            back_cnt_reg <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end else begin
            back_cnt_reg <= back_cnt_next;
            b1_valid_reg <= q_pop;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    // Cell address of this true class and winner.
    assign b1_addr = CA'(32'(b1_item_reg.tc) * ncc_pkg::NUM_CENTERS + 32'(b1_item_reg.idx));
    assign b1_count_en = (b1_item_reg.op == ncc_pkg::OP_COUNT)
                      && (32'(b1_item_reg.tc) < ncc_pkg::NUM_CENTERS);

    always_ff @(posedge aclk) begin
        b1_item_reg     <= q_item;
        b2_item_reg     <= b1_item_reg;
        b2_addr_reg     <= b1_addr;
        b2_count_en_reg <= b1_count_en;
    end

    // Counter memory: registered read in the first back stage.
    always_ff @(posedge aclk) begin
        rd_data_reg <= cell_mem[b1_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[b2_addr_reg] <= cnt_new;
        end
    end

    // The write of the word just ahead is not yet in the read data; forward it.
    // A cell whose valid bit is clear reads as zero.
    always_comb begin
        fwd     = last_wr_reg && (last_addr_reg == b2_addr_reg);
        cnt_old = !cell_vld_reg[b2_addr_reg] ? '0 :
                  (fwd ? last_data_reg : rd_data_reg);
        cnt_new = (cnt_old == ncc_pkg::COUNT_MAX) ? cnt_old : (cnt_old + 1'b1);
        wr_en   = b2_valid_reg && b2_count_en_reg;
        clr     = b2_valid_reg && (b2_item_reg.op == ncc_pkg::OP_CLEAR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg <= '0;
            last_wr_reg  <= 1'b0;
        end else begin
            if (clr) begin
                cell_vld_reg <= '0;
            end else if (wr_en) begin
                cell_vld_reg[b2_addr_reg] <= 1'b1;
            end
            last_wr_reg <= wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        last_addr_reg <= b2_addr_reg;
        last_data_reg <= cnt_new;
    end

    // Result fields fitted to the stream widths.
    always_comb begin
        winner_ext = {{ncc_pkg::WINNER_W{1'b0}}, b2_item_reg.idx};
        dist_ext   = {{ncc_pkg::MIN_DIST_W{1'b0}}, b2_item_reg.dist_sq};
        cell_ext   = {{ncc_pkg::CELL_W{1'b0}}, cnt_new};
        res_winner = clr ? '0 : winner_ext[ncc_pkg::WINNER_W-1:0];
        res_dist   = clr ? '0 : dist_ext[ncc_pkg::MIN_DIST_W-1:0];
        res_cell   = wr_en ? cell_ext[ncc_pkg::CELL_W-1:0] : '0;
    end

    // Result buffer toward the output stream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_wr_ptr_reg <= '0;
            ob_rd_ptr_reg <= '0;
            ob_cnt_reg    <= '0;
        end else begin
            if (b2_valid_reg) begin
                ob_wr_ptr_reg <= ob_wr_ptr_reg + 1'b1;
            end
            if (take) begin
                ob_rd_ptr_reg <= ob_rd_ptr_reg + 1'b1;
            end
            ob_cnt_reg <= ob_cnt_reg + (AW+1)'(b2_valid_reg) - (AW+1)'(take);
        end
    end

    always_ff @(posedge aclk) begin
        if (b2_valid_reg) begin
            ob_reg[ob_wr_ptr_reg] <= ncc_pkg::OUT_TDATA_W'({res_cell, res_dist, res_winner});
        end
    end

    assign m_axis_tvalid = (ob_cnt_reg != '0);
    assign m_axis_tdata  = ob_reg[ob_rd_ptr_reg];

endmodule

/* rtl/core/nearest_centroid_confusion_counter_top.sv */
// Path: a word accepted on s_axis passes the distance pipeline and minimum tree,
// the queue and the counter update before it shows on m_axis.
// Throughput: one word per cycle without stalls; the counter read, increment and write
// of one cell completes every cycle, with the write of the word just ahead forwarded.
// Reset: synchronous, active low; all centres and matrix cells read as zero at once.
module nearest_centroid_confusion_counter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_axis_tdata fields from bit 0: sample_x, sample_y, sample_z, true_class.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ncc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // s_axis_tuser fields from bit 0: op.
    input  logic [ncc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    // m_axis_tdata fields from bit 0: winner, min_distance, cell_count.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ncc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [ncc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ncc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int SB  = ncc_pkg::SAMPLE_BITS;
    localparam int QAW = ncc_pkg::QUEUE_AW;

    ncc_pkg::centers_t     center_reg;
    logic [ncc_pkg::CTR_W+ncc_pkg::CFG_DATA_W-1:0] cfg_ext;

    ncc_pkg::in_item_t     in_item;
    logic                  in_accept;
    logic [QAW:0]          credit_reg;
    logic [QAW:0]          credit_next;

    logic                  front_valid;
    ncc_pkg::front_item_t  front_item;
    ncc_pkg::front_item_t  q_head;
    ncc_pkg::q_stat_t      q_stat;
    logic                  q_pop;

    // Centre registers; writes beyond the list are dropped.
    assign cfg_ext = {{ncc_pkg::CTR_W{1'b0}}, cfg_wdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
        end else begin
            for (int i = 0; i < ncc_pkg::NUM_CENTERS; i++) begin
                if (cfg_wr_en && (32'(cfg_index) == i) && (i < ncc_pkg::NUM_CFG)) begin
                    center_reg[i] <= cfg_ext[ncc_pkg::CTR_W-1:0];
                end
            end
        end
    end

    // Input word unpacking.
    assign in_item.op = s_axis_tuser[ncc_pkg::OP_W-1:0];
    assign in_item.sx = s_axis_tdata[SB-1:0];
    assign in_item.sy = s_axis_tdata[2*SB-1:SB];
    assign in_item.sz = s_axis_tdata[3*SB-1:2*SB];
    assign in_item.tc = s_axis_tdata[3*SB+ncc_pkg::TC_W-1:3*SB];

    // Credits cover the front pipeline and the queue, so the front never stalls.
    assign s_axis_tready = (credit_reg < (QAW+1)'(ncc_pkg::QUEUE_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign credit_next   = credit_reg + (QAW+1)'(in_accept) - (QAW+1)'(q_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    ncc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_accept),
        .in_item   (in_item),
        .centers   (center_reg),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    ncc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    ncc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Outstanding words never exceed what the queue can hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= (QAW+1)'(ncc_pkg::QUEUE_DEPTH))
        else $error("credit count above queue depth");

    // The queue is never pushed while full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (front_valid && !q_pop) |-> (q_stat.count < (QAW+1)'(ncc_pkg::QUEUE_DEPTH)))
        else $error("queue overflow");

    // The queue holds no more words than have credits out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= credit_reg)
        else $error("queue holds words without credit");

endmodule
